// File: src/fpa_pkg.sv
// Package for the fixed-point ALU: opcodes, default parameters, shared types.
// No dependencies.
package fpa_pkg;

    localparam int DefFracBits = 8;
    localparam int DefWordBits = 32;
    localparam int IoBits      = 32;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_TOI  = 4'd8,
        OP_FROMI = 4'd9
    } fpa_op_t;

    // Comparison flags of A against B.
    typedef struct packed {
        logic gt;
        logic lt;
        logic eq;
    } fpa_cmp_t;

endpackage

// File: src/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with stall support.
// Depends on fpa_pkg.
module fpa_div
    import fpa_pkg::*;
#(
    parameter int NumBits = 40,
    parameter int DenBits = 32,
    parameter int TagBits = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [NumBits-1:0]        num,
    input  logic [DenBits-1:0]        den,
    input  logic                      neg,
    input  logic [TagBits-1:0]        tag,
    output logic                      out_valid,
    output logic [NumBits-1:0]        quo,
    output logic                      out_neg,
    output logic [TagBits-1:0]        out_tag
);

    logic [NumBits:0]   valid_reg;
    logic [NumBits-1:0] rem_reg [NumBits+1];
    logic [NumBits-1:0] q_reg   [NumBits+1];
    logic [DenBits-1:0] den_reg [NumBits+1];
    logic               neg_reg [NumBits+1];
    logic [TagBits-1:0] tag_reg [NumBits+1];

    // Stage 0 captures the magnitudes; stage i+1 settles one quotient bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NumBits-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            q_reg[0]   <= num;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            tag_reg[0] <= tag;
        end
    end

    for (genvar i = 0; i < NumBits; i++)
    begin : g_stage
        logic [NumBits:0]   trial;
        logic [NumBits-1:0] shifted;
        always_comb
        begin
            shifted = {rem_reg[i][NumBits-2:0], q_reg[i][NumBits-1]};
            trial   = {1'b0, shifted} - {{(NumBits+1-DenBits){1'b0}}, den_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= trial[NumBits] ? shifted : trial[NumBits-1:0];
                q_reg[i+1]   <= {q_reg[i][NumBits-2:0], ~trial[NumBits]};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[NumBits];
    assign quo       = q_reg[NumBits];
    assign out_neg   = neg_reg[NumBits];
    assign out_tag   = tag_reg[NumBits];

endmodule

// File: src/fixed_point_alu_unit.sv
// Top level of the fixed-point ALU: stream ports, operand stage, multiplier,
// simple ops, and the shared divider pipeline. Depends on fpa_pkg, fpa_div.
// Every transaction passes the operand stage, divider and output register (all ops
// share one pipeline depth, set by the one-bit-per-stage divider).
// Throughput: one transaction per cycle; the whole pipe stalls when the
// output register is full and not taken. Reset clears all valid bits.
module fixed_point_alu_unit
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = DefFracBits,
    parameter int WORD_BITS = DefWordBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result[31:0], a_greater, a_less, a_equal,
                                   // divide_by_zero, zeros
);

    localparam int NumBits = WORD_BITS + FRAC_BITS;
    localparam int TagBits = 4 + WORD_BITS + 4;

    logic [3:0]            func;
    logic [WORD_BITS-1:0]  a_w;
    logic [WORD_BITS-1:0]  b_w;
    logic                  en;

    // Payload carried beside the divider: op, side result and flags.
    logic [3:0]            op_reg;
    logic [WORD_BITS-1:0]  r_reg;
    fpa_cmp_t              cmp_reg;
    logic                  dz_reg;
    logic                  v1_reg;
    logic [NumBits-1:0]    num_reg;
    logic [WORD_BITS-1:0]  den_reg;
    logic                  neg_reg;

    logic signed [2*WORD_BITS-1:0] prod_next;
    logic signed [WORD_BITS-1:0]   as;
    logic signed [WORD_BITS-1:0]   bs;
    logic [WORD_BITS-1:0]          r_next;
    fpa_cmp_t                      cmp_next;

    logic                  dv_valid;
    logic [NumBits-1:0]    dv_quo;
    logic                  dv_neg;
    logic [TagBits-1:0]    dv_tag;
    logic [WORD_BITS-1:0]  mul_reg;
    logic                  mulv_reg;
    logic [WORD_BITS-1:0]  fin_next;
    logic [WORD_BITS-1:0]  quo_w;

    logic                  out_v_reg;
    logic [WORD_BITS-1:0]  out_r_reg;
    fpa_cmp_t              out_cmp_reg;
    logic                  out_dz_reg;

    assign func = s_tdata[3:0];
    assign a_w  = s_tdata[4 +: WORD_BITS];
    assign b_w  = s_tdata[36 +: WORD_BITS];
    assign as   = a_w;
    assign bs   = b_w;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // Stage 1 logic: compare, simple ops, divider operand magnitudes.
    always_comb
    begin
        cmp_next.gt = as > bs;
        cmp_next.lt = as < bs;
        cmp_next.eq = a_w == b_w;
        case (func)
            OP_ADD:   r_next = a_w + b_w;
            OP_SUB:   r_next = a_w - b_w;
            OP_MIN:   r_next = cmp_next.lt ? a_w : b_w;
            OP_MAX:   r_next = cmp_next.gt ? a_w : b_w;
            OP_INC:   r_next = a_w + 1'b1;
            OP_DEC:   r_next = a_w - 1'b1;
            OP_TOI:   r_next = WORD_BITS'(as >>> FRAC_BITS);
            OP_FROMI: r_next = a_w << FRAC_BITS;
            default:  r_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg  <= func;
            r_reg   <= r_next;
            cmp_reg <= cmp_next;
            dz_reg  <= (func == OP_DIV) && (b_w == '0);
            num_reg <= {(as[WORD_BITS-1] ? -a_w : a_w), {FRAC_BITS{1'b0}}};
            den_reg <= bs[WORD_BITS-1] ? -b_w : b_w;
            neg_reg <= as[WORD_BITS-1] ^ bs[WORD_BITS-1];
        end
    end

    // Multiplier, registered then shifted in a delay line that matches the
    // operand stage plus the full divider depth.
    assign prod_next = as * bs;

    logic [WORD_BITS-1:0] mul_dly_reg [NumBits+2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_dly_reg[0] <= WORD_BITS'(prod_next >>> FRAC_BITS);
        end
    end
    for (genvar k = 0; k < NumBits + 1; k++)
    begin : g_mdly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mul_dly_reg[k+1] <= mul_dly_reg[k];
            end
        end
    end
    assign mul_reg  = mul_dly_reg[NumBits+1];
    assign mulv_reg = 1'b1;

    fpa_div #(
        .NumBits (NumBits),
        .DenBits (WORD_BITS),
        .TagBits (TagBits)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .num       (num_reg),
        .den       (den_reg),
        .neg       (neg_reg),
        .tag       ({op_reg, r_reg, cmp_reg, dz_reg}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_neg   (dv_neg),
        .out_tag   (dv_tag)
    );

    // Final select: quotient sign fix, multiply result or side result.
    assign quo_w = dv_neg ? -dv_quo[WORD_BITS-1:0] : dv_quo[WORD_BITS-1:0];
    always_comb
    begin
        case (dv_tag[TagBits-1 -: 4])
            OP_MUL:  fin_next = mul_reg;
            OP_DIV:  fin_next = dv_tag[0] ? '0 : quo_w;
            default: fin_next = dv_tag[4 +: WORD_BITS];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_valid && mulv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_r_reg   <= fin_next;
            out_cmp_reg <= dv_tag[3:1];
            out_dz_reg  <= dv_tag[0];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'b0, out_dz_reg, out_cmp_reg.eq, out_cmp_reg.lt, out_cmp_reg.gt,
                       {(IoBits-WORD_BITS){out_r_reg[WORD_BITS-1]}}, out_r_reg};

    // A held result must stay put while the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    // Greater and less never both set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("both greater and less flagged");
    // Ready follows the output register state.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule
